### src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacer
// Holds the store geometry, operation and status codes, and the control
// bundle that the top level drives into every cell of the chain.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAGE_ID_BITS = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS   = 2 + PAGE_ID_BITS;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 + PAGE_ID_BITS + CNT_W;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_VICTIM = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Control shared by all cells in one cycle
    typedef struct packed {
        logic                    capture;       // latch compare result
        logic                    apply_insert;  // write id into the tail cell
        logic                    apply_victim;  // shift whole chain toward head
        logic                    apply_erase;   // shift from the hit cell on
        logic [PAGE_ID_BITS-1:0] id;            // compare / write identifier
    } t_cell_ctrl;

endpackage

### src/lru_page_replacer.sv
// ----------------------------------------------------------------------------
// lru_page_replacer: age-ordered page store with insert, victim and erase
// A chain of cells keeps identifiers oldest first; a small controller
// compares, shifts and counts, and holds the result in an output register.
// ----------------------------------------------------------------------------
// Timing: the compare result is registered in the accepting cycle, and the
//   execute state that follows applies it and registers the result.
// Flow: no new transaction is taken while the execute state runs, set by the
//   compare-then-shift pass over the cell chain; a new input is taken while
//   the previous result is being taken.
// Reset: synchronous active-low i_rst_n empties the store (count zero) and
//   drops any pending result; identifiers are not cleared.
module lru_page_replacer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0: opcode[1:0], page_id[PAGE_ID_BITS+1:2], zero pad
    input  logic [lpr_pkg::IN_TDATA-1:0]     i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0: status[1:0], victim_page, occupancy, zero pad
    output logic [lpr_pkg::OUT_TDATA-1:0]    o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready
);
    import lpr_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [1:0]              r_op;
    logic [PAGE_ID_BITS-1:0] r_id;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [1:0]              n_status;
    logic [PAGE_ID_BITS-1:0] r_victim;
    logic [PAGE_ID_BITS-1:0] n_victim;
    logic [CNT_W-1:0]        r_occ;

    logic                    s_accept;
    logic                    any_hit;
    t_cell_ctrl              cell_ctrl;

    logic [CAPACITY-1:0]     hit;
    logic [CAPACITY:0]       seen;
    logic [PAGE_ID_BITS-1:0] page [CAPACITY+1];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign any_hit    = |hit;

    // Cell chain, oldest at index 0
    assign seen[0]        = 1'b0;
    assign page[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        lpr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl),
            .i_occupied  (IDX < r_count),
            .i_tail      (IDX == r_count),
            .i_seen      (seen[g]),
            .i_next_page (page[g+1]),
            .o_seen      (seen[g+1]),
            .o_hit       (hit[g]),
            .o_page      (page[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: cell control, result and new count
    always_comb begin
        cell_ctrl              = '0;
        cell_ctrl.capture      = s_accept;
        cell_ctrl.id           = s_accept ? i_s_tdata[2 +: PAGE_ID_BITS] : r_id;
        n_status               = ST_DONE;
        n_victim               = '0;
        n_count                = r_count;
        if (r_state == S_EXEC) begin
            cell_ctrl.id = r_id;
            case (r_op)
                OP_INSERT: begin
                    if (any_hit) begin
                        n_status = ST_PRESENT;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        cell_ctrl.apply_insert = 1'b1;
                        n_count                = r_count + 1'b1;
                    end
                end
                OP_VICTIM: begin
                    if (r_count == '0) begin
                        n_status = ST_ABSENT;
                    end else begin
                        cell_ctrl.apply_victim = 1'b1;
                        n_victim               = page[0];
                        n_count                = r_count - 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (!any_hit) begin
                        n_status = ST_ABSENT;
                    end else begin
                        cell_ctrl.apply_erase = 1'b1;
                        n_count               = r_count - 1'b1;
                    end
                end
                OP_NONE: begin
                    n_status = ST_DONE;
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op <= i_s_tdata[1:0];
            r_id <= i_s_tdata[2 +: PAGE_ID_BITS];
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_victim <= n_victim;
            r_occ    <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA - OUT_BITS){1'b0}}, r_occ, r_victim, r_status};

endmodule

### src/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell: one slot of the age-ordered page chain
// Holds one identifier, compares it against the request, and takes its
// newer neighbor's identifier when the chain closes a gap at or before it.
// ----------------------------------------------------------------------------
module lpr_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpr_pkg::t_cell_ctrl             i_ctrl,
    input  logic                            i_occupied,   // slot below count
    input  logic                            i_tail,       // first free slot
    input  logic                            i_seen,       // hit in an older cell
    input  logic [lpr_pkg::PAGE_ID_BITS-1:0] i_next_page, // newer neighbor
    output logic                            o_seen,
    output logic                            o_hit,
    output logic [lpr_pkg::PAGE_ID_BITS-1:0] o_page
);
    import lpr_pkg::*;

    logic [PAGE_ID_BITS-1:0] r_page;
    logic                    r_hit;
    logic                    n_hit;
    logic                    shift;

    // Pass the erase point down the chain
    assign o_seen = i_seen | r_hit;
    assign shift  = i_ctrl.apply_victim | (i_ctrl.apply_erase & o_seen);
    assign n_hit  = i_occupied & (r_page == i_ctrl.id);

    // Hold the compare result for the execute cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_hit <= n_hit;
        end
    end

    // Advance the newer neighbor in, or take a new identifier at the tail
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_page <= i_next_page;
        end else if (i_ctrl.apply_insert && i_tail) begin
            r_page <= i_ctrl.id;
        end
    end

    assign o_hit  = r_hit;
    assign o_page = r_page;

endmodule

### src/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker: port-level checks of the LRU page replacer
// Watches the stream ports for result consistency and output holding.
// ----------------------------------------------------------------------------
module lpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic [lpr_pkg::OUT_TDATA-1:0] o_m_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready
);
    import lpr_pkg::*;

    logic [1:0]              status;
    logic [PAGE_ID_BITS-1:0] victim;
    logic [CNT_W-1:0]        occ;

    assign status = o_m_tdata[1:0];
    assign victim = o_m_tdata[2 +: PAGE_ID_BITS];
    assign occ    = o_m_tdata[2 + PAGE_ID_BITS +: CNT_W];

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No new transaction while a stalled result is pending
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while result stalled");

    // Occupancy never exceeds the store size
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // A dropped insert reports a full store
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status == ST_FULL |-> occ == CNT_W'(CAPACITY))
        else $error("full status with free space");

    // A failed operation returns a zero victim page
    a_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status != ST_DONE |-> victim == '0)
        else $error("victim page on a failed operation");

endmodule

bind lru_page_replacer lpr_checker u_lpr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

### test/lru_page_replacer_test.sv
// ----------------------------------------------------------------------------
// lru_page_replacer_test: self-checking bench for the LRU page replacer
// Drives insert, victim, erase and no-op transactions through the input
// stream and tracks the age-ordered page store in a scoreboard. Every result
// on the output stream is checked field by field against the tracked store.
// A directed opening covers empty, full and duplicate cases; random traffic
// follows with bursty input, patterned output stalls, a long output hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module lru_page_replacer_test;

    import lpr_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int RANDOM_ITEMS = 400;
    localparam int POOL_SIZE    = 24;    // more ids than slots, so hits and misses mix

    typedef struct packed {
        logic [1:0]              status;
        logic [PAGE_ID_BITS-1:0] victim;
        logic [CNT_W-1:0]        occupancy;
    } t_outcome;

    // Track the page store and the results it must produce
    class page_age_tracker;
        logic [PAGE_ID_BITS-1:0] pages [CAPACITY];
        int                      held;
        t_outcome                expected_results [$];
        int                      fault_count;

        function new();
            held        = 0;
            fault_count = 0;
        endfunction

        function int find_page(logic [PAGE_ID_BITS-1:0] id);
            for (int i = 0; i < held; i++) begin
                if (pages[i] == id) return i;
            end
            return -1;
        endfunction

        // Remove one slot and close the gap, keeping age order
        function void drop_slot(int slot);
            for (int i = slot; i + 1 < held; i++) pages[i] = pages[i + 1];
            held--;
        endfunction

        // Apply an accepted request and queue the result it causes
        function void note_request(logic [1:0] op, logic [PAGE_ID_BITS-1:0] id);
            t_outcome res;
            int       slot;
            res.status = ST_DONE;
            res.victim = '0;
            case (op)
                OP_INSERT: begin
                    if (find_page(id) >= 0) begin
                        res.status = ST_PRESENT;
                    end else if (held >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        pages[held] = id;
                        held++;
                    end
                end
                OP_VICTIM: begin
                    if (held == 0) begin
                        res.status = ST_ABSENT;
                    end else begin
                        res.victim = pages[0];
                        drop_slot(0);
                    end
                end
                OP_ERASE: begin
                    slot = find_page(id);
                    if (slot < 0) res.status = ST_ABSENT;
                    else drop_slot(slot);
                end
                default: ;
            endcase
            res.occupancy = held[CNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [OUT_TDATA-1:0] tdata);
            t_outcome got;
            t_outcome want;
            got.status    = tdata[1:0];
            got.victim    = tdata[2 +: PAGE_ID_BITS];
            got.occupancy = tdata[2 + PAGE_ID_BITS +: CNT_W];
            if (expected_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d victim %h occupancy %0d",
                             got.status, got.victim, got.occupancy);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.victim !== want.victim ||
                got.occupancy !== want.occupancy) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $write("mismatch: expected status %0d victim %h occupancy %0d,",
                           want.status, want.victim, want.occupancy);
                    $display(" got status %0d victim %h occupancy %0d",
                             got.status, got.victim, got.occupancy);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic [IN_TDATA-1:0]  i_s_tdata;   // opcode[1:0], page_id, zero pad
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [OUT_TDATA-1:0] o_m_tdata;   // status[1:0], victim_page, occupancy, zero pad
    logic                 o_m_tvalid;
    logic                 i_m_tready;

    page_age_tracker         tracker;
    bit                      hold_request;
    int                      idle_cycles;
    logic [PAGE_ID_BITS-1:0] id_pool [POOL_SIZE];

    lru_page_replacer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // Clock: period 12
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Offer one request and hold it until the block takes it
    task automatic offer_request(input logic [1:0] op, input logic [PAGE_ID_BITS-1:0] id);
        @(negedge i_clk);
        i_s_tvalid                    = 1'b1;
        i_s_tdata                     = '0;
        i_s_tdata[1:0]                = op;
        i_s_tdata[2 +: PAGE_ID_BITS]  = id;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_request(op, id);
    endtask

    // Drop valid for a given number of cycles, first waiting until every result is back when draining
    task automatic idle_sender(input int cycles, input bit drain);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        if (drain) begin
            while (tracker.pending() > 0) @(negedge i_clk);
        end
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Receiver: a stall pattern that is picked anew at random from time to time, plus one long hold-off
    initial begin
        int mode;
        int hold_left;
        int cyc;
        mode      = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(3);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_m_tready   = 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = 1'($urandom_range(1));
                    2: i_m_tready = ($urandom_range(3) == 0);
                    default: i_m_tready = (cyc % 3 != 0);
                endcase
            end
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("lru_page_replacer_test NOT OK");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int       burst_left;
        int       insert_weight;
        int       pick;
        logic [1:0] op;
        logic [PAGE_ID_BITS-1:0] id;

        tracker      = new();
        hold_request = 1'b0;
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty store: victim and erase both report absent
        offer_request(OP_VICTIM, 32'h0000_0000);
        offer_request(OP_ERASE,  32'h0000_1234);
        // Extreme ids, a duplicate, the unused opcode, then back to empty
        offer_request(OP_INSERT, 32'h0000_0000);
        offer_request(OP_INSERT, 32'hFFFF_FFFF);
        offer_request(OP_INSERT, 32'h0000_0000);
        offer_request(OP_NONE,   32'hA5A5_A5A5);
        offer_request(OP_VICTIM, 32'hFFFF_FFFF);
        offer_request(OP_ERASE,  32'hFFFF_FFFF);
        // Fill to capacity, then a new id is dropped and a held id wins over full
        for (int i = 0; i < CAPACITY; i++) offer_request(OP_INSERT, 32'h1111_1111 * i + 1);
        offer_request(OP_INSERT, 32'hDEAD_BEEF);
        offer_request(OP_INSERT, 32'h1111_1111 * 3 + 1);
        // Erase from the middle, keep age order of the rest
        offer_request(OP_ERASE,  32'h1111_1111 * 7 + 1);
        idle_sender(1, 1'b1);

        // Random traffic in bursts, with insert bias shifting to sweep occupancy
        burst_left    = 0;
        insert_weight = 45;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                pick          = $urandom_range(2);
                insert_weight = (pick == 0) ? 20 : (pick == 1) ? 45 : 75;
            end
            if (n == 150) hold_request = 1'b1;
            if (n == 300) idle_sender(1, 1'b1);
            if (burst_left == 0) begin
                idle_sender($urandom_range(1, 12), 1'b0);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            pick = $urandom_range(99);
            if (pick < insert_weight)                           op = OP_INSERT;
            else if (pick < insert_weight + (96 - insert_weight) / 2) op = OP_VICTIM;
            else if (pick < 96)                                 op = OP_ERASE;
            else                                                op = OP_NONE;
            id = ($urandom_range(3) == 0) ? $urandom : id_pool[$urandom_range(POOL_SIZE - 1)];
            offer_request(op, id);
        end

        // Drain and let the pipeline settle
        idle_sender(1, 1'b1);
        repeat (8) @(posedge i_clk);
        tracker.fault_count += tracker.pending();
        if (tracker.fault_count == 0) begin
            $display("lru_page_replacer_test OK");
        end else begin
            $display("lru_page_replacer_test NOT OK");
        end
        $finish;
    end

endmodule
